@@ src/reply_frame_builder_top_defines.svh @@
// assertion macros for the reply frame builder checker
// clocked on clk, disabled while arst_n is low
`ifndef REPLY_FRAME_BUILDER_TOP_DEFINES_SVH
`define REPLY_FRAME_BUILDER_TOP_DEFINES_SVH

// condition that must hold at every clock edge
`define RFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked from one edge to the next
`define RFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rfb_pkg.sv @@
// shared types, constants and key table for the reply frame builder
// no dependencies
package rfb_pkg;

	localparam int KEY_LENGTH = 16;
	localparam int KEY_W      = $clog2(KEY_LENGTH);
	localparam int RUN_MAX    = 8;
	localparam int RUN_IDX_W  = $clog2(RUN_MAX);

	localparam logic [7:0] HDR_B0 = 8'hAB;
	localparam logic [7:0] HDR_B1 = 8'hCD;
	localparam logic [7:0] FTR_B0 = 8'hDC;
	localparam logic [7:0] FTR_B1 = 8'hBA;
	localparam logic [7:0] PAD_B  = 8'hFF;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        command;
		logic [15:0] frame_length;
		logic [7:0]  payload_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       last_of_run;
		logic       frame_complete;
		logic       sequence_error;
	} out_word_t;

	// one decoded item: the bytes it emits and how to flag them
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] seq;
		logic [RUN_IDX_W-1:0]    last_idx;
		logic                    complete;
		logic                    err;
	} run_t;

	function automatic logic [7:0] key_at(input logic [KEY_W-1:0] idx);
		logic [7:0] k;
		case (idx)
			4'd0:    k = 8'h16;
			4'd1:    k = 8'h6C;
			4'd2:    k = 8'h14;
			4'd3:    k = 8'hE6;
			4'd4:    k = 8'h2E;
			4'd5:    k = 8'h91;
			4'd6:    k = 8'h0D;
			4'd7:    k = 8'h40;
			4'd8:    k = 8'h21;
			4'd9:    k = 8'h35;
			4'd10:   k = 8'hD5;
			4'd11:   k = 8'h40;
			4'd12:   k = 8'h13;
			4'd13:   k = 8'h03;
			4'd14:   k = 8'hE9;
			4'd15:   k = 8'h80;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

@@ src/reply_frame_builder_top.sv @@
// reply frame builder: input word to framed byte stream
// depends on rfb_pkg, rfb_decode, rfb_serial
//
// Input channel (in_valid/in_stall/in_word): a start word opens a frame of
// frame_length payload bytes, a data word carries one payload byte.
// Output channel (out_valid/out_stall/out_word): one wire byte per word.
// A start emits AB CD and the length (low, high); a zero length adds the
// footer at once. A data word emits its byte, keyed when obfuscation is on,
// and the last one adds the footer (two keyed FF pads, DC, BA). A data word
// with no open frame, or a start mid-frame, gives one error word.
// A word's results pass the decode register and then the output stage
// register on their way to the output. The output gives one result per
// cycle while out_stall is low; a word has 1 to 8 results, all sent by the
// single-byte output stage.
// A decode register sits between the sides, so one word is taken while the
// output stage is still sending. A stalled output holds its word and the
// stall reaches the input once the decode register is full.
// Reset clears the frame state, empties both stages and sets obfuscation on.
// obfuscate_we/obfuscate_wdata write the register; write it only when idle.
module reply_frame_builder_top import rfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      obfuscate_we,
	input  logic      obfuscate_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic run_valid;
	logic run_take;
	run_t run_word;

	rfb_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.obfuscate_we    (obfuscate_we),
		.obfuscate_wdata (obfuscate_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_word         (in_word),
		.run_valid       (run_valid),
		.run_word        (run_word),
		.run_take        (run_take)
	);

	rfb_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run_word  (run_word),
		.run_take  (run_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

@@ src/rfb_decode.sv @@
// frame state and item decode: turns one input word into a run of bytes
// depends on rfb_pkg
module rfb_decode import rfb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     obfuscate_we,
	input  logic     obfuscate_wdata,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	output logic     run_valid,
	output run_t     run_word,
	input  logic     run_take
);

	logic        obfuscate_q;
	logic        frame_open_q;
	logic [15:0] expected_length_q;
	logic [15:0] byte_position_q;
	logic        valid_s1;
	run_t        run_s1;

	run_t        run_next;
	logic        open_next;
	logic [15:0] len_next;
	logic [15:0] pos_next;
	logic [15:0] pos_inc;
	logic [15:0] ftr_len;
	logic [7:0]  pad0;
	logic [7:0]  pad1;
	logic [7:0]  data_b;
	logic        accept;

	assign in_stall  = valid_s1 && !run_take;
	assign accept    = in_valid && !in_stall;
	assign run_valid = valid_s1;
	assign run_word  = run_s1;

	assign pos_inc = byte_position_q + 16'd1;
	// footer keys are taken at the frame length, from the start item or the open frame
	assign ftr_len = (in_word.command == CMD_START) ? in_word.frame_length : expected_length_q;
	assign pad0 = PAD_B ^ (obfuscate_q ? key_at(ftr_len[KEY_W-1:0]) : 8'h00);
	assign pad1 = PAD_B ^ (obfuscate_q ? key_at(ftr_len[KEY_W-1:0] + KEY_W'(1)) : 8'h00);
	assign data_b = in_word.payload_byte
		^ (obfuscate_q ? key_at(byte_position_q[KEY_W-1:0]) : 8'h00);

	always_comb begin
		run_next  = '0;
		open_next = frame_open_q;
		len_next  = expected_length_q;
		pos_next  = byte_position_q;
		if ((in_word.command == CMD_START) == frame_open_q) begin
			// restart mid-frame or stray data byte
			run_next.err = 1'b1;
		end else if (in_word.command == CMD_START) begin
			run_next.seq[0] = HDR_B0;
			run_next.seq[1] = HDR_B1;
			run_next.seq[2] = in_word.frame_length[7:0];
			run_next.seq[3] = in_word.frame_length[15:8];
			run_next.seq[4] = pad0;
			run_next.seq[5] = pad1;
			run_next.seq[6] = FTR_B0;
			run_next.seq[7] = FTR_B1;
			len_next = in_word.frame_length;
			pos_next = '0;
			if (in_word.frame_length == 16'd0) begin
				run_next.last_idx = RUN_IDX_W'(7);
				run_next.complete = 1'b1;
				open_next         = 1'b0;
			end else begin
				run_next.last_idx = RUN_IDX_W'(3);
				open_next         = 1'b1;
			end
		end else begin
			run_next.seq[0] = data_b;
			run_next.seq[1] = pad0;
			run_next.seq[2] = pad1;
			run_next.seq[3] = FTR_B0;
			run_next.seq[4] = FTR_B1;
			if (pos_inc >= expected_length_q) begin
				run_next.last_idx = RUN_IDX_W'(4);
				run_next.complete = 1'b1;
				open_next         = 1'b0;
				pos_next          = '0;
			end else begin
				pos_next = pos_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obfuscate_q       <= 1'b1;
			frame_open_q      <= 1'b0;
			expected_length_q <= '0;
			byte_position_q   <= '0;
			valid_s1          <= 1'b0;
		end else begin
			if (obfuscate_we) begin
				obfuscate_q <= obfuscate_wdata;
			end
			if (accept) begin
				frame_open_q      <= open_next;
				expected_length_q <= len_next;
				byte_position_q   <= pos_next;
				valid_s1          <= 1'b1;
			end else if (run_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= run_next;
		end
	end

endmodule

@@ src/rfb_serial.sv @@
// output stage: holds one run and sends its bytes one word per cycle while out_stall is low
// depends on rfb_pkg
module rfb_serial import rfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_valid,
	input  run_t      run_word,
	output logic      run_take,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	run_t                 run_s2;
	logic                 valid_s2;
	logic [RUN_IDX_W-1:0] idx_q;
	logic                 at_last;
	logic                 fire;

	assign at_last  = (idx_q == run_s2.last_idx);
	assign fire     = valid_s2 && !out_stall;
	assign run_take = run_valid && (!valid_s2 || (fire && at_last));

	assign out_valid               = valid_s2;
	assign out_word.wire_byte      = run_s2.err ? 8'h00 : run_s2.seq[idx_q];
	assign out_word.last_of_run    = at_last;
	assign out_word.frame_complete = at_last && run_s2.complete;
	assign out_word.sequence_error = run_s2.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (run_take) begin
				valid_s2 <= 1'b1;
				idx_q    <= '0;
			end else if (fire) begin
				if (at_last) begin
					valid_s2 <= 1'b0;
					idx_q    <= '0;
				end else begin
					idx_q <= idx_q + RUN_IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_take) begin
			run_s2 <= run_word;
		end
	end

endmodule

@@ src/rfb_checker.sv @@
// port-level checks for the reply frame builder, bound to the top level
// depends on rfb_pkg and reply_frame_builder_top_defines.svh
`include "reply_frame_builder_top_defines.svh"

module rfb_checker import rfb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_word_t  in_word,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	// a stalled input word stays put
	`RFB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word), "in word changed under stall")

	// a stalled word stays put
	`RFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "out word changed under stall")

	// an error word stands alone with a zero byte
	`RFB_ASSERT(a_err_word, !(out_valid && out_word.sequence_error) || (out_word.last_of_run && !out_word.frame_complete && out_word.wire_byte == 8'h00), "bad error word")

	// a frame closes on BA, the final word of its run
	`RFB_ASSERT(a_complete, !(out_valid && out_word.frame_complete) || (out_word.last_of_run && out_word.wire_byte == FTR_B1), "bad frame end")

	// a run that is not finished keeps the output busy
	`RFB_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !out_word.last_of_run, out_valid, "run cut short")

endmodule

bind reply_frame_builder_top rfb_checker u_rfb_checker (.*);
